FILE: src/pcyl_pkg.sv
// Package for the point-in-finite-cylinder test: widths, codes, payload structs.
// No dependencies; pcyl_if, the top level and the testbench import it.
package pcyl_pkg;

  localparam int DIMENSIONS = 3;
  localparam int COORD_W    = 32;
  localparam int DIFF_W     = COORD_W + 1;   // exact coordinate difference
  localparam int SIZE_W     = 34;            // radius/half-length after adjustment
  localparam int SIZEM_W    = SIZE_W + 1;    // size plus margin
  localparam int CMP_W      = SIZEM_W + 1;   // common signed compare width
  localparam int DIST_W     = 31;
  localparam int SQ_W       = 2 * DIFF_W;    // one square
  localparam int SUM1_W     = SQ_W;          // two radial squares, even width
  localparam int SUM2_W     = SQ_W + 2;      // zone/centre sums, even width
  localparam int ROOT1_W    = SUM1_W / 2;
  localparam int ROOT2_W    = SUM2_W / 2;
  localparam int ADDR_W     = 5;

  localparam logic [2:0] REG_RADIUS      = 3'd0;
  localparam logic [2:0] REG_HALF_LENGTH = 3'd1;
  localparam logic [2:0] REG_AXIS        = 3'd2;
  localparam logic [2:0] REG_OFS_RADIUS  = 3'd3;
  localparam logic [2:0] REG_OFS_LENGTH  = 3'd4;
  localparam logic [2:0] REG_DIEL_ENABLE = 3'd5;
  localparam logic [2:0] REG_DIEL_MARGIN = 3'd6;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [DIST_W-1:0] SIZE_RESET = 31'd65536;
  localparam logic [DIST_W-1:0] DIST_MAX   = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [DIFF_W-1:0]         axial;
    logic signed [SIZE_W-1:0]  rad;
    logic signed [SIZE_W-1:0]  hl;
    logic signed [SIZEM_W-1:0] radm;
    logic signed [SIZEM_W-1:0] hlm;
    logic                      mode;
  } side1_t;

  typedef struct packed {
    logic in_cyl;
    logic near;
  } side2_t;

  typedef struct packed {
    logic              in_cyl;
    logic              near;
    logic [DIST_W-1:0] pot;
    logic [DIST_W-1:0] zone;
  } res_t;

endpackage

FILE: src/pcyl_if.sv
// Channel interfaces of the cylinder test: input beat and result beat.
// Depends on pcyl_pkg for the field widths.
interface pcyl_in_if;
  import pcyl_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  logic signed [COORD_W-1:0] centre_x;
  logic signed [COORD_W-1:0] centre_y;
  logic signed [COORD_W-1:0] centre_z;
  logic signed [COORD_W-1:0] size_adjustment;
  logic                      centre_distance_mode;

  modport source (output valid, point_x, point_y, point_z, centre_x, centre_y,
                  centre_z, size_adjustment, centre_distance_mode, input ready);
  modport sink (input valid, point_x, point_y, point_z, centre_x, centre_y,
                centre_z, size_adjustment, centre_distance_mode, output ready);
endinterface

interface pcyl_out_if;
  import pcyl_pkg::*;
  logic              valid;
  logic              ready;
  logic              inside_res;
  logic              near_dielectric;
  logic [DIST_W-1:0] potential_distance;
  logic [DIST_W-1:0] zone_distance;

  modport source (output valid, inside_res, near_dielectric, potential_distance,
                  zone_distance, input ready);
  modport sink (input valid, inside_res, near_dielectric, potential_distance,
                zone_distance, output ready);
endinterface

FILE: src/pcyl_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on nothing but its parameters; stalls on a shared advance enable.
module pcyl_sqrt_pipe #(
  parameter int IN_W   = 66,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  logic [IN_W-1:0]     in_val,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_vld,
  output logic [IN_W/2-1:0]   out_root,
  output logic [SIDE_W-1:0]   out_side
);
  localparam int N  = IN_W / 2;
  localparam int RW = N + 2;

  logic              vld_r  [N];
  logic [RW-1:0]     rem_r  [N];
  logic [N-1:0]      root_r [N];
  logic [IN_W-1:0]   x_r    [N];
  logic [SIDE_W-1:0] side_r [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic              vld_src;
    logic [RW-1:0]     rem_src;
    logic [N-1:0]      root_src;
    logic [IN_W-1:0]   x_src;
    logic [SIDE_W-1:0] side_src;
    logic [RW+1:0]     sh;
    logic [RW+1:0]     trial;
    logic [RW-1:0]     rem_nxt;
    logic [N-1:0]      root_nxt;

    if (i == 0) begin : g_first
      assign vld_src  = in_vld;
      assign rem_src  = '0;
      assign root_src = '0;
      assign x_src    = in_val;
      assign side_src = in_side;
    end else begin : g_next
      assign vld_src  = vld_r[i-1];
      assign rem_src  = rem_r[i-1];
      assign root_src = root_r[i-1];
      assign x_src    = x_r[i-1];
      assign side_src = side_r[i-1];
    end

    // Try (4*root + 1) against the remainder with the next bit pair
    always_comb begin
      sh       = {rem_src, x_src[IN_W-1 -: 2]};
      trial    = sh - {2'b00, root_src, 2'b01};
      root_nxt = {root_src[N-2:0], ~trial[RW+1]};
      rem_nxt  = trial[RW+1] ? sh[RW-1:0] : trial[RW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv) begin
        vld_r[i] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
        x_r[i]    <= {x_src[IN_W-3:0], 2'b00};
        side_r[i] <= side_src;
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_root = root_r[N-1];
  assign out_side = side_r[N-1];
endmodule

FILE: src/point_in_finite_cylinder_test.sv
// Top level of the point-in-finite-cylinder test: APB registers, pipeline, output queue.
// Depends on pcyl_pkg, pcyl_if and pcyl_sqrt_pipe.
//
//   channel   direction  handshake          payload
//   in_ch     sink       valid/ready        point, centre, size_adjustment, mode
//   out_ch    source     valid/ready        inside, near, potential, zone
//   cfg       APB slave  psel/penable       7 registers at byte address 4*i
//
// One beat enters per cycle while the output queue has a free entry; each beat passes
// four front stages, 33 root stages, three middle stages, 34 root stages, queue.
// The root pipelines (one result bit per stage) set the latency.
// rst_n is synchronous and clears valid bits, queue count and registers.
// A stalled output fills a two-entry queue; the pipeline freezes only when it is
// full, so no beat is lost or repeated and input is taken while a result waits.
module point_in_finite_cylinder_test (
  input  logic                     clk,
  input  logic                     rst_n,
  pcyl_in_if.sink                  in_ch,
  pcyl_out_if.source               out_ch,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [pcyl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import pcyl_pkg::*;

  // ---------------- configuration registers ----------------
  logic [DIST_W-1:0] radius_r, half_r, margin_r;
  logic [1:0]        axis_r;
  logic              ofs_rad_r, ofs_len_r, diel_en_r;
  logic [2:0]        reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= SIZE_RESET;
      half_r    <= SIZE_RESET;
      axis_r    <= AXIS_Z;
      ofs_rad_r <= 1'b0;
      ofs_len_r <= 1'b0;
      diel_en_r <= 1'b0;
      margin_r  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RADIUS:      radius_r  <= pwdata[DIST_W-1:0];
        REG_HALF_LENGTH: half_r    <= pwdata[DIST_W-1:0];
        REG_AXIS:        axis_r    <= pwdata[1:0];
        REG_OFS_RADIUS:  ofs_rad_r <= pwdata[0];
        REG_OFS_LENGTH:  ofs_len_r <= pwdata[0];
        REG_DIEL_ENABLE: diel_en_r <= pwdata[0];
        REG_DIEL_MARGIN: margin_r  <= pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RADIUS:      prdata = {1'b0, radius_r};
      REG_HALF_LENGTH: prdata = {1'b0, half_r};
      REG_AXIS:        prdata = {30'd0, axis_r};
      REG_OFS_RADIUS:  prdata = {31'd0, ofs_rad_r};
      REG_OFS_LENGTH:  prdata = {31'd0, ofs_len_r};
      REG_DIEL_ENABLE: prdata = {31'd0, diel_en_r};
      REG_DIEL_MARGIN: prdata = {1'b0, margin_r};
      default:         prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  // The whole pipeline advances while the output queue has a free entry.
  logic [1:0] cnt_r;
  logic       adv, in_acc;

  assign adv         = (cnt_r != 2'd2);
  assign in_ch.ready = adv;
  assign in_acc      = in_ch.valid && adv;

  // ---------------- stage 1: differences and effective sizes ----------------
  logic                     v1_r;
  logic signed [DIFF_W-1:0] d1_r [DIMENSIONS];
  logic signed [SIZE_W-1:0] rad1_r, hl1_r;
  logic                     mode1_r;
  logic signed [COORD_W-1:0] pt [DIMENSIONS];
  logic signed [COORD_W-1:0] ct [DIMENSIONS];
  logic signed [SIZE_W-1:0] adj_ext;

  assign pt[0] = in_ch.point_x;
  assign pt[1] = in_ch.point_y;
  assign pt[2] = in_ch.point_z;
  assign ct[0] = in_ch.centre_x;
  assign ct[1] = in_ch.centre_y;
  assign ct[2] = in_ch.centre_z;
  assign adj_ext = {{(SIZE_W-COORD_W){in_ch.size_adjustment[COORD_W-1]}},
                    in_ch.size_adjustment};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < DIMENSIONS; i++) begin
        d1_r[i] <= {pt[i][COORD_W-1], pt[i]} - {ct[i][COORD_W-1], ct[i]};
      end
      rad1_r  <= $signed({3'b000, radius_r}) + (ofs_rad_r ? adj_ext : '0);
      hl1_r   <= $signed({3'b000, half_r}) + (ofs_len_r ? adj_ext : '0);
      mode1_r <= in_ch.centre_distance_mode;
    end
  end

  // ---------------- stage 2: axis permutation, magnitudes, margins ----------------
  logic [DIFF_W-1:0] mag [DIMENSIONS];
  logic [DIFF_W-1:0] rad_a, rad_b, ax_m;
  logic              v2_r;
  logic [DIFF_W-1:0] m0_2_r, m1_2_r;
  side1_t            s2_r;

  always_comb begin
    for (int i = 0; i < DIMENSIONS; i++) begin
      mag[i] = d1_r[i][DIFF_W-1] ? (~d1_r[i] + 1'b1) : d1_r[i];
    end
    // Unused axis code falls back to the z axis
    case (axis_r)
      AXIS_X:  begin rad_a = mag[1]; rad_b = mag[2]; ax_m = mag[0]; end
      AXIS_Y:  begin rad_a = mag[2]; rad_b = mag[0]; ax_m = mag[1]; end
      AXIS_Z:  begin rad_a = mag[0]; rad_b = mag[1]; ax_m = mag[2]; end
      default: begin rad_a = mag[0]; rad_b = mag[1]; ax_m = mag[2]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m0_2_r     <= rad_a;
      m1_2_r     <= rad_b;
      s2_r.axial <= ax_m;
      s2_r.rad   <= rad1_r;
      s2_r.hl    <= hl1_r;
      s2_r.radm  <= {rad1_r[SIZE_W-1], rad1_r} + $signed({4'b0000, margin_r});
      s2_r.hlm   <= {hl1_r[SIZE_W-1], hl1_r} + $signed({4'b0000, margin_r});
      s2_r.mode  <= mode1_r;
    end
  end

  // ---------------- stage 3: radial squares ----------------
  logic            v3_r;
  logic [SQ_W-1:0] sq0_3_r, sq1_3_r;
  side1_t          s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq0_3_r <= m0_2_r * m0_2_r;
      sq1_3_r <= m1_2_r * m1_2_r;
      s3_r    <= s2_r;
    end
  end

  // ---------------- stage 4: radial sum ----------------
  logic              v4_r;
  logic [SUM1_W-1:0] sum4_r;
  side1_t            s4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum4_r <= sq0_3_r + sq1_3_r;
      s4_r   <= s3_r;
    end
  end

  // ---------------- radial root ----------------
  logic                 vr;
  logic [ROOT1_W-1:0]   r_root;
  logic [$bits(side1_t)-1:0] sr_bits;
  side1_t               sr;

  pcyl_sqrt_pipe #(.IN_W(SUM1_W), .SIDE_W($bits(side1_t))) u_root_radial (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (v4_r),
    .in_val   (sum4_r),
    .in_side  (s4_r),
    .out_vld  (vr),
    .out_root (r_root),
    .out_side (sr_bits)
  );
  assign sr = side1_t'(sr_bits);

  // ---------------- stage 5: compares and overshoots ----------------
  logic signed [CMP_W-1:0] r_c, a_c, rad_c, hl_c, radm_c, hlm_c, dr_w, dl_w;
  logic                    gt_r, gt_a;
  logic                    v5_r;
  logic [DIFF_W-1:0]       dr5_r, dl5_r, rr5_r, aa5_r;
  side2_t                  s5_r;
  logic                    mode5_r;

  always_comb begin
    r_c    = $signed({{(CMP_W-ROOT1_W){1'b0}}, r_root});
    a_c    = $signed({{(CMP_W-DIFF_W){1'b0}}, sr.axial});
    rad_c  = {{(CMP_W-SIZE_W){sr.rad[SIZE_W-1]}}, sr.rad};
    hl_c   = {{(CMP_W-SIZE_W){sr.hl[SIZE_W-1]}}, sr.hl};
    radm_c = {{(CMP_W-SIZEM_W){sr.radm[SIZEM_W-1]}}, sr.radm};
    hlm_c  = {{(CMP_W-SIZEM_W){sr.hlm[SIZEM_W-1]}}, sr.hlm};
    gt_r   = r_c > rad_c;
    gt_a   = a_c > hl_c;
    dr_w   = r_c - rad_c;
    dl_w   = a_c - hl_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dr5_r       <= gt_r ? dr_w[DIFF_W-1:0] : '0;
      dl5_r       <= gt_a ? dl_w[DIFF_W-1:0] : '0;
      rr5_r       <= gt_r ? r_root : '0;
      aa5_r       <= gt_a ? sr.axial : '0;
      s5_r.in_cyl <= !gt_r && !gt_a;
      s5_r.near   <= diel_en_r && (r_c < radm_c) && (a_c < hlm_c);
      mode5_r     <= sr.mode;
    end
  end

  // ---------------- stage 6: squares for zone and centre distances ----------------
  logic            v6_r;
  logic [SQ_W-1:0] zdr6_r, zdl6_r, cr6_r, ca6_r;
  side2_t          s6_r;
  logic            mode6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (adv) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zdr6_r  <= dr5_r * dr5_r;
      zdl6_r  <= dl5_r * dl5_r;
      cr6_r   <= rr5_r * rr5_r;
      ca6_r   <= aa5_r * aa5_r;
      s6_r    <= s5_r;
      mode6_r <= mode5_r;
    end
  end

  // ---------------- stage 7: sums ----------------
  logic              v7_r;
  logic [SUM2_W-1:0] zsq7_r, csq7_r;
  side2_t            s7_r;
  logic              mode7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (adv) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zsq7_r  <= {2'b00, zdr6_r} + {2'b00, zdl6_r};
      csq7_r  <= {2'b00, cr6_r} + {2'b00, ca6_r};
      s7_r    <= s6_r;
      mode7_r <= mode6_r;
    end
  end

  // ---------------- zone and centre roots ----------------
  logic               vz, vc;
  logic [ROOT2_W-1:0] z_root, c_root;
  logic [$bits(side2_t)-1:0] sz_bits;
  side2_t             sz;
  logic               mode_c;

  pcyl_sqrt_pipe #(.IN_W(SUM2_W), .SIDE_W($bits(side2_t))) u_root_zone (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (v7_r),
    .in_val   (zsq7_r),
    .in_side  (s7_r),
    .out_vld  (vz),
    .out_root (z_root),
    .out_side (sz_bits)
  );

  pcyl_sqrt_pipe #(.IN_W(SUM2_W), .SIDE_W(1)) u_root_centre (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (v7_r),
    .in_val   (csq7_r),
    .in_side  (mode7_r),
    .out_vld  (vc),
    .out_root (c_root),
    .out_side (mode_c)
  );
  assign sz = side2_t'(sz_bits);

  // ---------------- saturate, select, queue ----------------
  res_t res_new;
  logic push, pop;
  res_t e0_r, e1_r;

  always_comb begin
    res_new.in_cyl = sz.in_cyl;
    res_new.near   = sz.near;
    res_new.zone   = (|z_root[ROOT2_W-1:DIST_W]) ? DIST_MAX : z_root[DIST_W-1:0];
    if (mode_c) begin
      res_new.pot = (|c_root[ROOT2_W-1:DIST_W]) ? DIST_MAX : c_root[DIST_W-1:0];
    end else begin
      res_new.pot = res_new.zone;
    end
  end

  assign push = adv && vz && vc;
  assign pop  = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Head entry is e0; advance e1 into it on a pop from a full queue
  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt_r == 2'd2) begin
        e0_r <= e1_r;
      end else if (push) begin
        e0_r <= res_new;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        e0_r <= res_new;
      end else begin
        e1_r <= res_new;
      end
    end
  end

  assign out_ch.valid              = (cnt_r != 2'd0);
  assign out_ch.inside_res         = e0_r.in_cyl;
  assign out_ch.near_dielectric    = e0_r.near;
  assign out_ch.potential_distance = e0_r.pot;
  assign out_ch.zone_distance      = e0_r.zone;

  // ---------------- assertions ----------------
  // A point inside the cylinder is on or within the surface: both distances are zero.
  a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.inside_res) |->
      (out_ch.zone_distance == '0 && out_ch.potential_distance == '0))
    else $error("inside result with nonzero distance");

  // The two root pipelines stay in lockstep.
  a_roots_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    vz == vc)
    else $error("root pipelines out of step");

  // A full queue without a pop stays full and takes no beat.
  a_queue_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> (cnt_r == 2'd2))
    else $error("queue count moved while full and stalled");

  // The queue never counts past its two entries.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue overflow");
endmodule

FILE: tb/sv/pcyl_tb_if.sv
// Testbench package: the input beat and expected result types of the checker.
// Depends on pcyl_pkg; the channel interfaces come from the block's pcyl_if file.
package pcyl_tb_pkg;
  import pcyl_pkg::*;

  typedef struct {
    logic signed [31:0] pt [3];
    logic signed [31:0] ct [3];
    logic signed [31:0] adj;
    logic               mode;
  } point_beat_t;

  typedef struct {
    logic              in_cyl;
    logic              near;
    logic [DIST_W-1:0] pot;
    logic [DIST_W-1:0] zone;
  } cyl_result_t;
endpackage

FILE: tb/sv/tb_top.sv
// Testbench top for point_in_finite_cylinder_test: directed and random point beats,
// a cylinder-distance predictor and an in-order result check.
// Depends on pcyl_pkg, pcyl_if (block files) and pcyl_tb_pkg.
module tb_top;
  import pcyl_pkg::*;
  import pcyl_tb_pkg::*;

  localparam int LATENCY   = 75;
  localparam int WDOG_MAX  = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pcyl_in_if  in_ch ();
  pcyl_out_if out_ch ();

  point_in_finite_cylinder_test i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Shadow copy of the block's registers.
  logic [30:0] sh_radius = 31'd65536, sh_half = 31'd65536, sh_margin = '0;
  logic [1:0]  sh_axis = AXIS_Z;
  logic        sh_ofs_r = 0, sh_ofs_l = 0, sh_diel = 0;

  cyl_result_t expected_q [$];
  int errors = 0;
  int idle_pct_in = 0, stall_pct_out = 0;
  bit hold_out = 0;
  int wdog = 0;

  // exact floor(sqrt(v)) for v below 2^84
  function automatic logic [63:0] isqrt(logic [83:0] v);
    logic [63:0] root;
    logic [63:0] c;
    root = '0;
    for (int b = 41; b >= 0; b--) begin
      c = root | (64'd1 << b);
      if ({20'd0, c} * {20'd0, c} <= v) root = c;
    end
    return root;
  endfunction

  function automatic logic [30:0] sat_dist(logic [63:0] v);
    return (v > 64'h7FFF_FFFF) ? DIST_MAX : v[30:0];
  endfunction

  function automatic cyl_result_t predict_cylinder(point_beat_t b);
    cyl_result_t res;
    int unsigned ra, rb, ax;
    logic signed [63:0] d0, d1, d2, rad, hl, mg, r, a, dr, dl;
    logic [83:0] sumsq, csq, zsq;
    case (sh_axis)
      AXIS_X:  begin ra = 1; rb = 2; ax = 0; end
      AXIS_Y:  begin ra = 2; rb = 0; ax = 1; end
      default: begin ra = 0; rb = 1; ax = 2; end  // code 3 behaves as z
    endcase
    d0 = 64'(b.pt[ra]) - 64'(b.ct[ra]);
    d1 = 64'(b.pt[rb]) - 64'(b.ct[rb]);
    d2 = 64'(b.ct[ax]) - 64'(b.pt[ax]);
    if (d0 < 0) d0 = -d0;
    if (d1 < 0) d1 = -d1;
    if (d2 < 0) d2 = -d2;
    sumsq = 84'(d0) * 84'(d0) + 84'(d1) * 84'(d1);
    r = isqrt(sumsq);
    a = d2;
    rad = 64'(sh_radius) + (sh_ofs_r ? 64'(b.adj) : 64'sd0);
    hl  = 64'(sh_half) + (sh_ofs_l ? 64'(b.adj) : 64'sd0);
    mg  = 64'(sh_margin);
    dr = 0; dl = 0; csq = '0;
    if (r > rad) begin dr = r - rad; csq += 84'(r) * 84'(r); end
    if (a > hl) begin dl = a - hl; csq += 84'(a) * 84'(a); end
    zsq = 84'(dr) * 84'(dr) + 84'(dl) * 84'(dl);
    res.zone = sat_dist(isqrt(zsq));
    res.pot = b.mode ? sat_dist(isqrt(csq)) : res.zone;
    res.in_cyl = (r <= rad) && (a <= hl);
    res.near = sh_diel && (r < rad + mg) && (a < hl + mg);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR %0t: %s got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  // Drive ready at each edge: long holds, random stalls.
  always @(posedge clk) begin
    if (hold_out) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= stall_pct_out);
  end

  // Check each result beat against the oldest prediction.
  always @(posedge clk) begin
    cyl_result_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        w = expected_q.pop_front();
        if (out_ch.inside_res !== w.in_cyl)
          report_mismatch("inside_res", out_ch.inside_res, w.in_cyl);
        if (out_ch.near_dielectric !== w.near)
          report_mismatch("near_dielectric", out_ch.near_dielectric, w.near);
        if (out_ch.potential_distance !== w.pot)
          report_mismatch("potential_distance", out_ch.potential_distance, w.pot);
        if (out_ch.zone_distance !== w.zone)
          report_mismatch("zone_distance", out_ch.zone_distance, w.zone);
      end
    end
  end

  // Watchdog: count cycles with no beat on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_out)
      wdog <= 0;
    else if (rst_n) begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Setup and access cycle; register takes the value on the access edge.
  // Back-to-back writes go straight into the next setup cycle.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_W'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_RADIUS:      sh_radius = val[30:0];
      REG_HALF_LENGTH: sh_half   = val[30:0];
      REG_AXIS:        sh_axis   = val[1:0];
      REG_OFS_RADIUS:  sh_ofs_r  = val[0];
      REG_OFS_LENGTH:  sh_ofs_l  = val[0];
      REG_DIEL_ENABLE: sh_diel   = val[0];
      default:         sh_margin = val[30:0];
    endcase
  endtask

  task automatic configure(logic [30:0] rad, logic [30:0] hl, logic [1:0] axis,
                           bit ofr, bit ofl, bit diel, logic [30:0] mg);
    write_reg(REG_RADIUS, 32'(rad));
    write_reg(REG_HALF_LENGTH, 32'(hl));
    write_reg(REG_AXIS, 32'(axis));
    write_reg(REG_OFS_RADIUS, 32'(ofr));
    write_reg(REG_OFS_LENGTH, 32'(ofl));
    write_reg(REG_DIEL_ENABLE, 32'(diel));
    write_reg(REG_DIEL_MARGIN, 32'(mg));
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // Offer one beat; advance on acceptance, predicting at that edge.
  // valid stays up for a following beat; idle cycles and drain drop it.
  task automatic send_point(point_beat_t b);
    while (idle_pct_in > 0 && $urandom_range(99) < idle_pct_in) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.point_x <= b.pt[0]; in_ch.point_y <= b.pt[1]; in_ch.point_z <= b.pt[2];
    in_ch.centre_x <= b.ct[0]; in_ch.centre_y <= b.ct[1]; in_ch.centre_z <= b.ct[2];
    in_ch.size_adjustment <= b.adj; in_ch.centre_distance_mode <= b.mode;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(predict_cylinder(b));
  endtask

  task automatic drain;
    in_ch.valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // Mostly small Q16.16 geometry near the cylinder, sometimes full range.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(8 << 16))) - 32'sd262144;
    endcase
  endfunction

  function automatic point_beat_t rand_point();
    point_beat_t b;
    for (int i = 0; i < 3; i++) begin
      b.ct[i] = rand_coord();
      b.pt[i] = ($urandom_range(3) != 0) ? b.ct[i] + ($urandom_range(6 << 16) - (3 << 16))
                                         : rand_coord();
    end
    b.adj = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(2 << 16) - (1 << 16);
    b.mode = $urandom_range(1);
    return b;
  endfunction

  task automatic test_directed;
    point_beat_t b;
    logic [31:0] ext [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
    idle_pct_in = 0; stall_pct_out = 0;
    for (int k = 0; k < 16; k++) begin
      for (int i = 0; i < 3; i++) begin
        b.pt[i] = ext[(k + i) % 4];
        b.ct[i] = ext[(k / 4 + i) % 4];
      end
      b.adj = ext[k % 4];
      b.mode = k[0];
      send_point(b);
    end
    // at the centre, then at 1.0 and just over 1.0 in x and z (Q16.16)
    b.pt = '{0, 0, 0}; b.ct = '{0, 0, 0}; b.adj = 0; b.mode = 0; send_point(b);
    b.pt = '{32'sd65536, 0, 32'sd65536}; send_point(b);
    b.pt = '{32'sd65537, 0, 32'sd65537}; b.mode = 1; send_point(b);
    drain();
  endtask

  task automatic test_settings;
    // each setting: extremes, negative effective sizes, axes x, y and the unused code 3
    configure(0, 0, AXIS_X, 1, 1, 1, 31'h7FFF_FFFF);
    test_directed();
    configure(31'h7FFF_FFFF, 31'h7FFF_FFFF, AXIS_Y, 0, 1, 1, 0);
    test_directed();
    configure(31'd65536, 31'd131072, 2'd3, 1, 0, 1, 31'd32768);
    test_directed();
  endtask

  task automatic run_random(int n, int in_pct, int out_pct);
    idle_pct_in = in_pct; stall_pct_out = out_pct;
    repeat (n) send_point(rand_point());
  endtask

  task automatic test_random;
    logic [1:0] axes [4] = '{AXIS_X, AXIS_Y, AXIS_Z, 2'd3};
    for (int p = 0; p < 4; p++) begin
      configure(31'($urandom_range(4 << 16)), 31'($urandom_range(4 << 16)), axes[p],
                $urandom_range(1), $urandom_range(1), $urandom_range(1),
                31'($urandom_range(1 << 16)));
      run_random(30, 0, 0);
      run_random(30, 58, 0);
      run_random(30, 0, 58);
      run_random(30, 27, 27);
      drain();
    end
  endtask

  task automatic test_backpressure;
    idle_pct_in = 0; stall_pct_out = 0;
    fork
      begin
        hold_out = 1;
        repeat (300) @(posedge clk);
        hold_out = 0;
      end
      run_random(90, 0, 0);
    join
    // pause until every result is back, then resume
    in_ch.valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    run_random(20, 0, 0);
    drain();
  endtask

  initial begin
    in_ch.valid = 0; out_ch.ready = 0;
    in_ch.point_x = 0; in_ch.point_y = 0; in_ch.point_z = 0;
    in_ch.centre_x = 0; in_ch.centre_y = 0; in_ch.centre_z = 0;
    in_ch.size_adjustment = 0; in_ch.centre_distance_mode = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    run_random(20, 0, 0);
    drain();
    test_settings();
    test_random();
    test_backpressure();
    configure(31'd65536, 31'd65536, AXIS_Z, 0, 0, 0, 0);
    run_random(20, 27, 27);
    drain();
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

FILE: point_in_finite_cylinder_test.f
src/pcyl_pkg.sv
src/pcyl_if.sv
src/pcyl_sqrt_pipe.sv
src/point_in_finite_cylinder_test.sv
tb/sv/pcyl_tb_if.sv
tb/sv/tb_top.sv
